@@ rtl/core/address_interval_merge_table_assert.svh @@
// ----------------------------------------------------------------------------
// Interval merge table assertion macros
// Concurrent assertion wrappers clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_INTERVAL_MERGE_TABLE_ASSERT_SVH
`define ADDRESS_INTERVAL_MERGE_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define AIMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check that a condition is followed by a consequence in the next cycle.
`define AIMT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define AIMT_ASSERT(lbl, prop, msg)
`define AIMT_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ rtl/core/aimt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval merge table package
// Item types, merge kinds and address bounds shared by the table and its cells.
// ----------------------------------------------------------------------------
package aimt_pkg;

    localparam int DefMaxEntries = 16;

    // Gap fill applies only if end+1 >= low bound and start < high bound
    localparam logic [16:0] LowFillBound  = 17'h00400;
    localparam logic [15:0] HighFillBound = 16'hC000;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef enum logic [2:0] {
        KIND_APPEND    = 3'd0,
        KIND_GAP_FILL  = 3'd1,
        KIND_AFTER     = 3'd2,
        KIND_BEFORE    = 3'd3,
        KIND_COVERED   = 3'd4,
        KIND_OVL_START = 3'd5,
        KIND_OVL_END   = 3'd6,
        KIND_FULL      = 3'd7
    } t_kind;

    typedef struct packed {
        logic        func;
        logic [15:0] seg_start;
        logic [15:0] seg_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  merge_kind;
        logic [3:0]  entry_index;
        logic [15:0] out_start;
        logic [15:0] out_end;
        logic        entry_valid;
        logic        last_item;
    } t_out_item;

    // One table entry as seen by the neighbor cell
    typedef struct packed {
        logic        vld;
        logic [15:0] s;
        logic [15:0] e;
    } t_entry;

    // Insert request walking down the chain, carrying its result once matched
    typedef struct packed {
        logic        busy;
        logic        done;
        t_kind       kind;
        logic [3:0]  idx;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] s;
        logic [15:0] e;
    } t_tok;

endpackage

@@ rtl/core/address_interval_merge_table.sv @@
`timescale 1ns / 1ps
// Insert: the request walks one cell per cycle unless the output stalls;
//   a new item is taken only once the result is loaded.
// Flush: one result per stored entry (one if empty), one per cycle unless the
//   output stalls; the next item is taken the cycle after the last result.
// Reset (synchronous, i_rst_n low): table empty, gap fill limit 0, no result.
// ----------------------------------------------------------------------------
// Address interval merge table
// Ordered table of address intervals held in a chain of cells; inserts merge
// into the first matching entry, append or report full; flushes stream it out.
// ----------------------------------------------------------------------------
module address_interval_merge_table import aimt_pkg::*; #(
    parameter int MAX_ENTRIES = DefMaxEntries
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // gap fill limit register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_FLUSH
    } t_state;

    t_state      r_state, n_state;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;
    logic [3:0]  r_flush_idx, n_flush_idx;
    logic [15:0] r_gap_limit;

    logic        w_in_accept;
    logic        w_out_free;
    logic        w_adv;
    logic        w_shift;
    logic        w_last;
    t_tok        w_new_tok;
    t_tok        w_end_tok;

    // w_tok[i] feeds cell i; w_tok[MAX_ENTRIES] leaves the last cell.
    // w_nbr[i] is the entry of cell i; w_nbr[MAX_ENTRIES] is an empty filler.
    t_tok        w_tok [MAX_ENTRIES+1];
    t_entry      w_nbr [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] w_vld;
    logic [MAX_ENTRIES-1:0] w_busy;
    logic [MAX_ENTRIES:0]   w_vld_inc;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_end_tok   = w_tok[MAX_ENTRIES];

    // Freeze the chain only while a request leaving it waits for the output
    assign w_adv = !(w_end_tok.busy && !w_out_free);

    always_comb begin
        w_new_tok      = '0;
        w_new_tok.busy = w_in_accept && (i_in_item.func == FUNC_INSERT);
        w_new_tok.kind = KIND_APPEND;
        w_new_tok.a    = i_in_item.seg_start;
        w_new_tok.b    = i_in_item.seg_end;
    end

    assign w_tok[0]           = w_new_tok;
    assign w_nbr[MAX_ENTRIES] = '0;

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        aimt_cell #(
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (w_adv),
            .i_shift     (w_shift),
            .i_gap_limit (r_gap_limit),
            .i_tok       (w_tok[gi]),
            .o_tok       (w_tok[gi+1]),
            .i_next      (w_nbr[gi+1]),
            .o_entry     (w_nbr[gi])
        );
        assign w_vld[gi]  = w_nbr[gi].vld;
        assign w_busy[gi] = w_tok[gi+1].busy;
    end

    assign w_vld_inc = {1'b0, w_vld} + {{MAX_ENTRIES{1'b0}}, 1'b1};

    // Last flush result when the entry behind the head is empty
    assign w_last = !w_nbr[1].vld;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_flush_idx = r_flush_idx;
        w_shift     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = (i_in_item.func == FUNC_FLUSH) ? ST_FLUSH : ST_INSERT;
                end
            end
            ST_INSERT: begin
                // Request leaving the chain unclaimed means the table is full
                if (w_end_tok.busy && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last_item = 1'b1;
                    if (w_end_tok.done) begin
                        n_out.merge_kind  = w_end_tok.kind;
                        n_out.entry_index = w_end_tok.idx;
                        n_out.out_start   = w_end_tok.s;
                        n_out.out_end     = w_end_tok.e;
                        n_out.entry_valid = 1'b1;
                    end else begin
                        n_out.merge_kind = KIND_FULL;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.last_item = 1'b1;
                    if (!w_nbr[0].vld) begin
                        // Empty table: a single empty result
                        n_state     = ST_IDLE;
                        n_flush_idx = '0;
                    end else begin
                        // Emit the head entry and advance the rest one cell
                        n_out.merge_kind  = KIND_APPEND;
                        n_out.entry_index = r_flush_idx;
                        n_out.out_start   = w_nbr[0].s;
                        n_out.out_end     = w_nbr[0].e;
                        n_out.entry_valid = 1'b1;
                        n_out.last_item   = w_last;
                        w_shift           = 1'b1;
                        if (w_last) begin
                            n_state     = ST_IDLE;
                            n_flush_idx = '0;
                        end else begin
                            n_flush_idx = r_flush_idx + 4'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_flush_idx <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_flush_idx <= n_flush_idx;
        end
        r_out <= n_out;
    end

    // Gap fill limit; user must write only while table is idle, not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gap_limit <= i_cfg_data;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

`include "address_interval_merge_table_assert.svh"

    `AIMT_ASSERT(a_full_only_when_full, (o_out_valid && (o_out_item.merge_kind == KIND_FULL)) |-> w_vld[MAX_ENTRIES-1], "table full reported with a free entry")
    `AIMT_ASSERT(a_entries_packed, $onehot(w_vld_inc), "valid entries are not packed from the head")
    `AIMT_ASSERT(a_single_request, $onehot0(w_busy), "more than one insert request in the chain")
    `AIMT_ASSERT_NEXT(a_insert_enters, w_in_accept && (i_in_item.func == FUNC_INSERT), w_busy[0], "insert request did not enter the first cell")
    `AIMT_ASSERT_NEXT(a_flush_empties, (r_state == ST_FLUSH) && w_out_free && w_last, !w_vld[0], "table not empty after the last flush item")

endmodule

@@ rtl/core/aimt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval merge table cell
// Holds one entry, applies the merge rules to a passing insert request and
// shifts its entry toward the head during a flush.
// ----------------------------------------------------------------------------
module aimt_cell import aimt_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_shift,
    input  logic [15:0] i_gap_limit,
    input  t_tok        i_tok,
    output t_tok        o_tok,
    input  t_entry      i_next,
    output t_entry      o_entry
);

    localparam logic [3:0] CellIdx4 = 4'(CELL_IDX);

    t_tok        r_tok;
    logic        r_vld;
    logic [15:0] r_start;
    logic [15:0] r_end;

    logic [16:0] w_s, w_e, w_a, w_b, w_e1, w_gap;
    logic        w_gap_hit, w_after, w_before, w_covered, w_ovl_start, w_ovl_end;
    logic        w_hit, w_upd;
    t_kind       w_kind;
    logic [15:0] n_start, n_end;

    // Rules work on 17 bits so that end+1 and the request's end+1 never wrap
    assign w_s   = {1'b0, r_start};
    assign w_e   = {1'b0, r_end};
    assign w_a   = {1'b0, r_tok.a};
    assign w_b   = {1'b0, r_tok.b};
    assign w_e1  = w_e + 17'd1;
    assign w_gap = w_a - w_e1;

    assign w_gap_hit   = (w_e1 >= LowFillBound) && (r_start < HighFillBound) &&
                         (w_e1 < w_a) && (w_gap < {1'b0, i_gap_limit});
    assign w_after     = (w_e1 == w_a);
    assign w_before    = ((w_b + 17'd1) == w_s);
    assign w_covered   = (w_s <= w_a) && (w_b <= w_e);
    assign w_ovl_start = (w_a <= w_s) && (w_s <= w_b);
    assign w_ovl_end   = (w_a <= w_e) && (w_e <= w_b);

    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        w_kind  = KIND_APPEND;
        w_hit   = 1'b1;
        if (w_gap_hit) begin
            n_end  = r_tok.b;
            w_kind = KIND_GAP_FILL;
        end else if (w_after) begin
            n_end  = r_tok.b;
            w_kind = KIND_AFTER;
        end else if (w_before) begin
            n_start = r_tok.a;
            w_kind  = KIND_BEFORE;
        end else if (w_covered) begin
            w_kind = KIND_COVERED;
        end else if (w_ovl_start) begin
            n_start = r_tok.a;
            if (w_e < w_b) begin
                n_end = r_tok.b;
            end
            w_kind = KIND_OVL_START;
        end else if (w_ovl_end) begin
            n_end = r_tok.b;
            if (w_s > w_a) begin
                n_start = r_tok.a;
            end
            w_kind = KIND_OVL_END;
        end else begin
            w_hit = 1'b0;
        end
    end

    // First matching entry, or the first free cell, claims the request
    always_comb begin
        o_tok = r_tok;
        if (r_tok.busy && !r_tok.done) begin
            if (!r_vld) begin
                o_tok.done = 1'b1;
                o_tok.kind = KIND_APPEND;
                o_tok.idx  = CellIdx4;
                o_tok.s    = r_tok.a;
                o_tok.e    = r_tok.b;
            end else if (w_hit) begin
                o_tok.done = 1'b1;
                o_tok.kind = w_kind;
                o_tok.idx  = CellIdx4;
                o_tok.s    = n_start;
                o_tok.e    = n_end;
            end
        end
    end

    assign w_upd   = i_adv && r_tok.busy && !r_tok.done;
    assign o_entry = '{vld: r_vld, s: r_start, e: r_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.busy <= 1'b0;
            r_vld      <= 1'b0;
        end else begin
            if (i_adv) begin
                r_tok <= i_tok;
            end
            if (i_shift) begin
                r_vld <= i_next.vld;
            end else if (w_upd && !r_vld) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_start <= i_next.s;
            r_end   <= i_next.e;
        end else if (w_upd && (!r_vld || w_hit)) begin
            r_start <= r_vld ? n_start : r_tok.a;
            r_end   <= r_vld ? n_end : r_tok.b;
        end
    end

endmodule
